/* design/sts_pkg.sv */
// package: constants, types and helpers shared by the sphere trace shader
package sts_pkg;

   localparam int MaxStepsDefault = 64;
   localparam int FracBitsDefault = 16;

   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 64;

   typedef enum logic [CsrIdxW-1:0] {
      REG_OFFSET_X  = 3'd0,
      REG_OFFSET_Y  = 3'd1,
      REG_OFFSET_Z  = 3'd2,
      REG_RADIUS    = 3'd3,
      REG_LIMIT     = 3'd4,
      REG_EPSILON   = 3'd5,
      REG_MATERIAL  = 3'd6,
      REG_SKY       = 3'd7
   } reg_index_type;

   localparam logic [31:0] OffsetXReset  = 32'sd0;
   localparam logic [31:0] OffsetYReset  = 32'sd0;
   localparam logic [31:0] OffsetZReset  = 32'd327680;
   localparam logic [30:0] RadiusReset   = 31'd65536;
   localparam logic [30:0] LimitReset    = 31'd6553600;
   localparam logic [15:0] EpsilonReset  = 16'd66;
   localparam logic [63:0] MaterialReset = 64'h103A9F4000000000;
   localparam logic [23:0] SkyReset      = 24'd0;
   localparam logic [3:0]  LightType     = 4'h1;

   // command from controller to datapath
   typedef struct packed {
      logic load;        // capture a new ray, clear t
      logic mul_start;   // start component products for current t
      logic sqrt_start;  // start root of the sum of squares
      logic step_update; // fold step into t
      logic finish;      // build result word
   } dp_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic t_below_limit;
      logic mul_done;
      logic sqrt_done;
      logic step_small;
   } dp_status_type;

   // byte to fixed point, round to nearest of b/255
   function automatic logic [31:0] byte_to_fix(input logic [7:0] b, input int frac_bits);
      logic [47:0] num;
      logic [47:0] q;
      logic [47:0] rem;
      num = ({40'd0, b} << frac_bits) + 48'd127;
      // divide by 255: q = num/255 via num*(1/255) series, then correct
      q   = (num + (num >> 8) + (num >> 16) + (num >> 24) + (num >> 32)) >> 8;
      rem = num - q * 48'd255;
      if (rem >= 48'd255) begin
         q = q + 48'd1;
      end
      return q[31:0];
   endfunction

endpackage

/* design/sts_if.sv */
// handshake channel interface with payload
interface sts_if #(parameter type PayloadType = logic) ();
   logic       valid;
   logic       ready;
   PayloadType data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* design/sts_sqrt.sv */
// iterative 66-bit integer square root, one result bit per cycle
module sts_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [65:0] radicand,
   output logic        done,
   output logic [32:0] root
);
   logic [65:0] rem_ff, rem_in;
   logic [32:0] root_ff, root_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [67:0] trial;
   logic [67:0] rem_shift;
   logic [65:0] rad_ff, rad_in;

   always_comb begin
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rad_in  = rad_ff;
      rem_shift = {rem_ff, rad_ff[65:64]};
      trial = {33'd0, root_ff, 2'b01};
      if (start) begin
         rem_in  = '0;
         root_in = '0;
         rad_in  = radicand;
         cnt_in  = 6'd33;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[63:0], 2'b00};
         if (rem_shift >= trial) begin
            rem_in  = 66'(rem_shift - trial);
            root_in = {root_ff[31:0], 1'b1};
         end else begin
            rem_in  = rem_shift[65:0];
            root_in = {root_ff[31:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      root_ff <= root_in;
      rad_ff  <= rad_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

/* design/sts_datapath.sv */
// datapath: point evaluation, squares, root, running t and colour sums
module sts_datapath #(
   parameter int FracBits = sts_pkg::FracBitsDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sts_pkg::dp_cmd_type    cmd,
   output sts_pkg::dp_status_type status,
   input  logic [31:0]            in_origin [3],
   input  logic [31:0]            in_dir [3],
   input  logic [31:0]            in_sum [3],
   input  logic [31:0]            offset [3],
   input  logic [30:0]            radius,
   input  logic [30:0]            limit,
   input  logic [15:0]            epsilon,
   input  logic [63:0]            material,
   input  logic [23:0]            sky,
   input  logic                   small_flag,
   output logic [31:0]            out_sum [3],
   output logic                   out_hit,
   output logic [31:0]            out_t
);
   logic signed [31:0] org_ff [3];
   logic signed [31:0] dir_ff [3];
   logic [31:0]        sum_ff [3];
   logic signed [31:0] t_ff, t_in;
   logic [1:0]         comp_ff;
   logic               mul_busy_ff;
   logic [1:0]         phase_ff;  // 0 product, 1 point, 2 square
   logic signed [63:0] prod_ff;
   logic signed [31:0] q_ff;
   logic [65:0]        sq_ff;
   logic               mul_done_ff;
   logic signed [63:0] step_ff;
   logic [31:0]        res_sum_ff [3];
   logic               res_hit_ff;
   logic               sqrt_done;
   logic [32:0]        root;
   logic signed [49:0] q_wide;
   logic signed [31:0] q_sat;
   logic signed [63:0] mul_a, mul_b, mul_p;
   logic signed [33:0] t_sum;
   logic               hit_now;
   logic [31:0]        add_v [3];
   logic [32:0]        s_wide [3];

   // one shared signed multiplier, 32x32
   assign mul_a = (phase_ff == 2'd0) ? 64'(t_ff) : 64'(q_ff);
   assign mul_b = (phase_ff == 2'd0) ? 64'(dir_ff[comp_ff]) : 64'(q_ff);
   assign mul_p = mul_a * mul_b;

   // point component: o + floor(t*d) + off, saturated
   assign q_wide = 50'(org_ff[comp_ff]) + 50'(prod_ff >>> FracBits)
                 + 50'($signed(offset[comp_ff]));
   assign q_sat = (q_wide > 50'sd2147483647) ? 32'sh7FFFFFFF :
                  (q_wide < -50'sd2147483648) ? 32'sh80000000 : q_wide[31:0];

   assign t_sum = 34'(t_ff) + ((step_ff > 64'sd2147483647) ? 34'sd2147483647 :
                  (step_ff < -64'sd2147483648) ? -34'sd2147483648 : 34'(step_ff));

   always_comb begin
      t_in = t_ff;
      if (cmd.load) begin
         t_in = '0;
      end else if (cmd.step_update) begin
         if (t_sum > 34'sd2147483647) t_in = 32'sh7FFFFFFF;
         else if (t_sum < -34'sd2147483648) t_in = 32'sh80000000;
         else t_in = t_sum[31:0];
      end
   end

   assign hit_now = small_flag && (t_ff < $signed({1'b0, limit}));
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (hit_now) begin
            if (material[63:60] == sts_pkg::LightType)
               add_v[k] = sts_pkg::byte_to_fix(material[59-8*k -: 8], FracBits);
            else
               add_v[k] = '0;
         end else begin
            add_v[k] = sts_pkg::byte_to_fix(sky[23-8*k -: 8], FracBits);
         end
         s_wide[k] = 33'(sum_ff[k]) + 33'(add_v[k]);
      end
   end

   sts_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.sqrt_start),
      .radicand (sq_ff),
      .done     (sqrt_done),
      .root     (root)
   );

   always_ff @(posedge clock) begin
      t_ff <= t_in;
      if (cmd.load) begin
         for (int k = 0; k < 3; k++) begin
            org_ff[k] <= in_origin[k];
            dir_ff[k] <= in_dir[k];
            sum_ff[k] <= in_sum[k];
         end
      end
      if (sqrt_done) begin
         step_ff <= 64'(root) - 64'(radius);
      end
      if (cmd.finish) begin
         for (int k = 0; k < 3; k++) begin
            res_sum_ff[k] <= s_wide[k][32] ? 32'hFFFFFFFF : s_wide[k][31:0];
         end
         res_hit_ff <= hit_now;
      end
      // per component: product, then square, accumulate
      if (cmd.mul_start) begin
         comp_ff <= '0;
         phase_ff <= 2'd0;
         sq_ff <= '0;
      end else if (mul_busy_ff) begin
         unique case (phase_ff)
            2'd0: begin
               prod_ff  <= mul_p;
               phase_ff <= 2'd1;
            end
            2'd1: begin
               q_ff     <= q_sat;
               phase_ff <= 2'd2;
            end
            2'd2: begin
               sq_ff    <= sq_ff + 66'(mul_p);
               phase_ff <= 2'd0;
               comp_ff  <= comp_ff + 2'd1;
            end
            default: phase_ff <= 2'd0;
         endcase
      end
      if (reset) begin
         mul_busy_ff <= 1'b0;
         mul_done_ff <= 1'b0;
      end else begin
         mul_done_ff <= !cmd.mul_start && mul_busy_ff && (phase_ff == 2'd2)
                        && (comp_ff == 2'd2);
         if (cmd.mul_start) begin
            mul_busy_ff <= 1'b1;
         end else if (mul_busy_ff && phase_ff == 2'd2 && comp_ff == 2'd2) begin
            mul_busy_ff <= 1'b0;
         end
      end
   end

   assign status.t_below_limit = t_ff < $signed({1'b0, limit});
   assign status.mul_done      = mul_done_ff;
   assign status.sqrt_done     = sqrt_done;
   // signed compare so a negative step counts as small
   assign status.step_small    = step_ff < $signed(64'(epsilon));
   assign out_sum = res_sum_ff;
   assign out_hit = res_hit_ff;
   assign out_t   = t_ff;
endmodule

/* design/sts_ctrl.sv */
// march controller: sequences steps, checks limits, hands off results
module sts_ctrl #(
   parameter int MaxSteps = sts_pkg::MaxStepsDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output sts_pkg::dp_cmd_type    cmd,
   input  sts_pkg::dp_status_type status,
   output logic                   small_flag
);
   localparam int CntW = $clog2(MaxSteps + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_CHECK, S_MUL, S_SQRT, S_STEP, S_TEST, S_DONE, S_OUT
   } state_type;

   state_type      state_ff;
   logic [CntW-1:0] steps_ff;
   logic           small_ff;
   logic           rsp_valid_ff;

   always_comb begin
      cmd = '0;
      cmd.load        = (state_ff == S_IDLE) && req_valid;
      cmd.mul_start   = (state_ff == S_CHECK) && status.t_below_limit
                        && (steps_ff < CntW'(MaxSteps));
      cmd.sqrt_start  = (state_ff == S_MUL) && status.mul_done;
      cmd.step_update = (state_ff == S_STEP);
      cmd.finish      = (state_ff == S_DONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         steps_ff     <= '0;
         small_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (req_valid) begin
               steps_ff <= '0;
               small_ff <= 1'b0;
               state_ff <= S_CHECK;
            end
            S_CHECK: state_ff <= cmd.mul_start ? S_MUL : S_DONE;
            S_MUL:   if (status.mul_done) state_ff <= S_SQRT;
            S_SQRT:  if (status.sqrt_done) state_ff <= S_STEP;
            S_STEP: begin
               steps_ff <= steps_ff + CntW'(1);
               state_ff <= S_TEST;
            end
            S_TEST: begin
               if (status.step_small) begin
                  small_ff <= 1'b1;
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_CHECK;
               end
            end
            S_DONE: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_OUT;
            end
            S_OUT: if (rsp_ready) begin
               rsp_valid_ff <= 1'b0;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign small_flag = small_ff;
endmodule

/* design/sphere_trace_shader.sv */
// Sphere trace shader: marches one ray per word against a single sphere in fixed point and
// adds the light or sky colour to the running sums. One ray at a time: each march step is one
// limit check, then three components through one shared 32x32 multiplier (product, point and
// square for each), then a bit-serial square root, then update and test. A ray ends on a small
// step, on the limit or on the step cap, and the block holds it until its result is taken. The
// square root sets the pace.
module sphere_trace_shader #(
   parameter int MaxSteps = sts_pkg::MaxStepsDefault,
   parameter int FracBits = sts_pkg::FracBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   sts_if.sink         req,
   sts_if.source       rsp,
   input  logic        csr_write_enable,
   input  logic [sts_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [sts_pkg::CsrDataW-1:0] csr_write_data
);
   logic [31:0] offset_ff [3];
   logic [30:0] radius_ff, limit_ff;
   logic [15:0] epsilon_ff;
   logic [63:0] material_ff;
   logic [23:0] sky_ff;
   logic [31:0] origin [3], dir [3], sum_in [3], sum_out [3];
   logic        hit, small_flag;
   logic [31:0] t_out;
   sts_pkg::dp_cmd_type    cmd;
   sts_pkg::dp_status_type status;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff[0] <= sts_pkg::OffsetXReset;
         offset_ff[1] <= sts_pkg::OffsetYReset;
         offset_ff[2] <= sts_pkg::OffsetZReset;
         radius_ff    <= sts_pkg::RadiusReset;
         limit_ff     <= sts_pkg::LimitReset;
         epsilon_ff   <= sts_pkg::EpsilonReset;
         material_ff  <= sts_pkg::MaterialReset;
         sky_ff       <= sts_pkg::SkyReset;
      end else if (csr_write_enable) begin
         unique case (sts_pkg::reg_index_type'(csr_index))
            sts_pkg::REG_OFFSET_X: offset_ff[0] <= csr_write_data[31:0];
            sts_pkg::REG_OFFSET_Y: offset_ff[1] <= csr_write_data[31:0];
            sts_pkg::REG_OFFSET_Z: offset_ff[2] <= csr_write_data[31:0];
            sts_pkg::REG_RADIUS:   radius_ff    <= csr_write_data[30:0];
            sts_pkg::REG_LIMIT:    limit_ff     <= csr_write_data[30:0];
            sts_pkg::REG_EPSILON:  epsilon_ff   <= csr_write_data[15:0];
            sts_pkg::REG_MATERIAL: material_ff  <= csr_write_data;
            sts_pkg::REG_SKY:      sky_ff       <= csr_write_data[23:0];
            default: ;
         endcase
      end
   end

   assign origin[0] = req.data.origin_x;
   assign origin[1] = req.data.origin_y;
   assign origin[2] = req.data.origin_z;
   assign dir[0]    = req.data.dir_x;
   assign dir[1]    = req.data.dir_y;
   assign dir[2]    = req.data.dir_z;
   assign sum_in[0] = req.data.sum_red_in;
   assign sum_in[1] = req.data.sum_green_in;
   assign sum_in[2] = req.data.sum_blue_in;

   sts_ctrl #(.MaxSteps(MaxSteps)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req.valid),
      .req_ready  (req.ready),
      .rsp_valid  (rsp.valid),
      .rsp_ready  (rsp.ready),
      .cmd        (cmd),
      .status     (status),
      .small_flag (small_flag)
   );

   sts_datapath #(.FracBits(FracBits)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .in_origin  (origin),
      .in_dir     (dir),
      .in_sum     (sum_in),
      .offset     (offset_ff),
      .radius     (radius_ff),
      .limit      (limit_ff),
      .epsilon    (epsilon_ff),
      .material   (material_ff),
      .sky        (sky_ff),
      .small_flag (small_flag),
      .out_sum    (sum_out),
      .out_hit    (hit),
      .out_t      (t_out)
   );

   assign rsp.data.sum_red_out   = sum_out[0];
   assign rsp.data.sum_green_out = sum_out[1];
   assign rsp.data.sum_blue_out  = sum_out[2];
   assign rsp.data.ray_hit       = hit;
   assign rsp.data.hit_distance  = t_out;

   // no new word taken while a result waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("input taken while result pending");
   // a result leaves the block idle next cycle
   a_ret_idle: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready |=> req.ready) else $error("not idle after result");
   // a hit never reports a distance at or past the limit
   a_hit_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.data.ray_hit |-> $signed(t_out) < $signed({1'b0, limit_ff}))
      else $error("hit beyond limit");
endmodule
